[hw/rtl/rc4ks_pkg.sv]
// Shared constants and types of the RC4 drop-N keystream cipher.
package rc4ks_pkg;

   localparam int unsigned TABLE_SIZE       = 256;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned KEY_MAX_DEFAULT  = 256;
   localparam int unsigned DISCARD_W        = 16;
   localparam int unsigned CSR_INDEX_W      = 8;
   localparam int unsigned CSR_DATA_W       = 16;

   localparam logic [DISCARD_W-1:0]   DISCARD_RESET      = 16'd4096;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISCARD_COUNT  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEYSTREAM_ONLY = 8'd1;

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   // strobes from the front end into the engine
   typedef struct packed {
      logic                  key_we;
      logic [BYTE_W-1:0]     key_byte;
      logic                  sched_go;
      logic                  gen_go;
      logic [DISCARD_W-1:0]  discard;
   } eng_ctl_type;

   // engine status back to the front end
   typedef struct packed {
      logic              busy;
      logic              sched_done;
      logic              ks_valid;
      logic [BYTE_W-1:0] ks_byte;
   } eng_sts_type;

endpackage

[hw/rtl/rc4ks_engine.sv]
// Permutation and key stores with the sequencer that runs key schedule and generator.
module rc4ks_engine
   import rc4ks_pkg::*;
#(
   parameter int unsigned KEY_MAX_BYTES = KEY_MAX_DEFAULT,
   parameter int unsigned KEY_AW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1,
   parameter int unsigned LEN_W  = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES + 1) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  eng_ctl_type       ctl,
   input  logic [KEY_AW-1:0] key_addr,
   input  logic [LEN_W-1:0]  key_len,
   output eng_sts_type       sts
);

   typedef enum logic [11:0] {
      E_IDLE  = 12'b0000_0000_0001,
      E_FILL  = 12'b0000_0000_0010,
      E_KRD   = 12'b0000_0000_0100,
      E_KMIX  = 12'b0000_0000_1000,
      E_KWR_N = 12'b0000_0001_0000,
      E_KWR_J = 12'b0000_0010_0000,
      E_GRD_I = 12'b0000_0100_0000,
      E_GRD_J = 12'b0000_1000_0000,
      E_GWR_I = 12'b0001_0000_0000,
      E_GWR_J = 12'b0010_0000_0000,
      E_GRD_T = 12'b0100_0000_0000,
      E_GOUT  = 12'b1000_0000_0000
   } eng_state_type;

   logic [BYTE_W-1:0] s_mem   [TABLE_SIZE];
   logic [BYTE_W-1:0] key_mem [KEY_MAX_BYTES];

   eng_state_type       st_ff, st_in;
   logic [BYTE_W-1:0]   n_ff, n_in;
   logic [BYTE_W-1:0]   i_ff, i_in;
   logic [BYTE_W-1:0]   j_ff, j_in;
   logic [BYTE_W-1:0]   t_ff, t_in;
   logic [BYTE_W-1:0]   u_ff, u_in;
   logic [KEY_AW-1:0]   kidx_ff, kidx_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [DISCARD_W-1:0] disc_ff, disc_in;
   logic                drop_ff, drop_in;

   logic                s_we;
   logic [BYTE_W-1:0]   s_waddr, s_wdata, s_raddr, s_rdata_ff;
   logic [KEY_AW-1:0]   key_raddr;
   logic [BYTE_W-1:0]   key_rdata_ff;

   logic [BYTE_W-1:0]   i_inc, j_gen, j_mix;
   logic [LEN_W-1:0]    kidx_inc;

   assign i_inc    = i_ff + 1'b1;
   assign j_gen    = j_ff + s_rdata_ff;
   assign j_mix    = j_gen + key_rdata_ff;
   assign kidx_inc = LEN_W'(kidx_ff) + 1'b1;

   // permutation store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (s_we) begin
         s_mem[s_waddr] <= s_wdata;
      end
      s_rdata_ff <= s_mem[s_raddr];
   end

   // key store
   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[key_addr] <= ctl.key_byte;
      end
      key_rdata_ff <= key_mem[key_raddr];
   end

   always_comb begin
      st_in     = st_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      u_in      = u_ff;
      kidx_in   = kidx_ff;
      len_in    = len_ff;
      disc_in   = disc_ff;
      drop_in   = drop_ff;
      s_we      = 1'b0;
      s_waddr   = n_ff;
      s_wdata   = t_ff;
      s_raddr   = n_ff;
      key_raddr = kidx_ff;
      sts.busy       = (st_ff != E_IDLE);
      sts.sched_done = 1'b0;
      sts.ks_valid   = 1'b0;
      sts.ks_byte    = s_rdata_ff;
      case (st_ff)
         E_IDLE: begin
            if (ctl.sched_go) begin
               st_in   = E_FILL;
               n_in    = '0;
               len_in  = key_len;
               disc_in = ctl.discard;
            end else if (ctl.gen_go) begin
               st_in   = E_GRD_I;
               drop_in = 1'b0;
            end
         end
         E_FILL: begin
            // load identity
            s_we    = 1'b1;
            s_waddr = n_ff;
            s_wdata = n_ff;
            n_in    = n_ff + 1'b1;
            if (n_ff == BYTE_W'(TABLE_SIZE - 1)) begin
               st_in   = E_KRD;
               j_in    = '0;
               kidx_in = '0;
            end
         end
         E_KRD: begin
            s_raddr   = n_ff;
            key_raddr = kidx_ff;
            st_in     = E_KMIX;
         end
         E_KMIX: begin
            t_in    = s_rdata_ff;
            j_in    = j_mix;
            s_raddr = j_mix;
            st_in   = E_KWR_N;
         end
         E_KWR_N: begin
            s_we    = 1'b1;
            s_waddr = n_ff;
            s_wdata = s_rdata_ff;
            st_in   = E_KWR_J;
         end
         E_KWR_J: begin
            s_we    = 1'b1;
            s_waddr = j_ff;
            s_wdata = t_ff;
            n_in    = n_ff + 1'b1;
            // repeat the key cyclically
            if (kidx_inc >= len_ff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_inc[KEY_AW-1:0];
            end
            if (n_ff == BYTE_W'(TABLE_SIZE - 1)) begin
               i_in = '0;
               j_in = '0;
               if (disc_ff == '0) begin
                  st_in          = E_IDLE;
                  sts.sched_done = 1'b1;
               end else begin
                  st_in   = E_GRD_I;
                  drop_in = 1'b1;
               end
            end else begin
               st_in = E_KRD;
            end
         end
         E_GRD_I: begin
            i_in    = i_inc;
            s_raddr = i_inc;
            st_in   = E_GRD_J;
         end
         E_GRD_J: begin
            t_in    = s_rdata_ff;
            j_in    = j_gen;
            s_raddr = j_gen;
            st_in   = E_GWR_I;
         end
         E_GWR_I: begin
            s_we    = 1'b1;
            s_waddr = i_ff;
            s_wdata = s_rdata_ff;
            u_in    = t_ff + s_rdata_ff;
            st_in   = E_GWR_J;
         end
         E_GWR_J: begin
            s_we    = 1'b1;
            s_waddr = j_ff;
            s_wdata = t_ff;
            if (drop_ff) begin
               disc_in = disc_ff - 1'b1;
               if (disc_ff == DISCARD_W'(1)) begin
                  st_in          = E_IDLE;
                  drop_in        = 1'b0;
                  sts.sched_done = 1'b1;
               end else begin
                  st_in = E_GRD_I;
               end
            end else begin
               st_in = E_GRD_T;
            end
         end
         E_GRD_T: begin
            s_raddr = u_ff;
            st_in   = E_GOUT;
         end
         E_GOUT: begin
            sts.ks_valid = 1'b1;
            st_in        = E_IDLE;
         end
         default: begin
            st_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= E_IDLE;
         i_ff    <= '0;
         j_ff    <= '0;
         drop_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      t_ff    <= t_in;
      u_ff    <= u_in;
      kidx_ff <= kidx_in;
      len_ff  <= len_in;
      disc_ff <= disc_in;
   end

endmodule

[hw/rtl/rc4_keystream_cipher.sv]
// Top level of the RC4 drop-N keystream cipher: stream ports, registers, result word.
//
// Key bytes (req_tuser low) are stored one per cycle while req_tready is high; the
// byte marked with req_tlast starts the key schedule. Bytes beyond KEY_MAX_BYTES are
// dropped, but a marked one still starts the schedule over the bytes already held.
// The schedule runs on one 256 x 8 permutation memory with a single read and a single
// write port, shared by every step: it loads the identity, mixes in the key one entry
// at a time, then generates and drops discard_count keystream bytes; req_tready stays
// low from the acceptance of the marked byte until the schedule is done.
// A key byte that does not start a schedule leaves req_tready high. A data byte
// (req_tuser high) runs through the engine steps read S[i], read S[j], two swap
// writes, read S[S[i]+S[j]], hand over the byte; its word is then loaded into the
// output register once that is free, and the next byte can go in after that load.
// Data before any completed schedule returns 0 with rsp_tuser high via the result
// register. The output register lets a finished word wait while the next item is
// taken. Write the CSR port only while the block is idle; discard_count applies from
// the next schedule, keystream_only from the next data byte.
module rc4_keystream_cipher
   import rc4ks_pkg::*;
#(
   parameter int unsigned KEY_MAX_BYTES = KEY_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_value
   input  logic                   req_tuser,   // [0] command
   input  logic                   req_tlast,   // last_key_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] result_value
   output logic                   rsp_tuser,   // [0] not_keyed
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned KEY_AW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
   localparam int unsigned LEN_W  = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES + 1) : 1;

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_WAIT = 3'b010,
      T_RESP = 3'b100
   } top_state_type;

   top_state_type        st_ff, st_in;
   logic [LEN_W-1:0]     key_len_ff, key_len_in;
   logic                 keyed_ff, keyed_in;
   logic [DISCARD_W-1:0] discard_ff;
   logic                 ks_only_ff;
   logic [BYTE_W-1:0]    data_ff, data_in;
   logic [BYTE_W-1:0]    res_ff, res_in;
   logic                 nk_ff, nk_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [BYTE_W-1:0]    rsp_tdata_ff, rsp_tdata_in;
   logic                 rsp_tuser_ff, rsp_tuser_in;

   logic                 req_accept;
   logic                 key_room;
   logic [LEN_W-1:0]     key_len_inc;
   logic [LEN_W-1:0]     sched_len;
   eng_ctl_type          ctl;
   eng_sts_type          sts;

   assign req_tready  = (st_ff == T_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_tvalid_ff;
   assign rsp_tdata   = rsp_tdata_ff;
   assign rsp_tuser   = rsp_tuser_ff;

   assign key_room    = (key_len_ff < LEN_W'(KEY_MAX_BYTES));
   assign key_len_inc = key_len_ff + 1'b1;
   // length the schedule sees, counting this byte if it fits
   assign sched_len   = key_room ? key_len_inc : key_len_ff;

   rc4ks_engine #(
      .KEY_MAX_BYTES (KEY_MAX_BYTES),
      .KEY_AW        (KEY_AW),
      .LEN_W         (LEN_W)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .key_addr (key_len_ff[KEY_AW-1:0]),
      .key_len  (sched_len),
      .sts      (sts)
   );

   always_comb begin
      st_in         = st_ff;
      key_len_in    = key_len_ff;
      keyed_in      = keyed_ff;
      data_in       = data_ff;
      res_in        = res_ff;
      nk_in         = nk_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      ctl.key_we    = 1'b0;
      ctl.key_byte  = req_tdata;
      ctl.sched_go  = 1'b0;
      ctl.gen_go    = 1'b0;
      ctl.discard   = discard_ff;
      case (st_ff)
         T_IDLE: begin
            if (req_accept) begin
               if (req_tuser == CMD_KEY) begin
                  // store the key byte while room remains
                  if (key_room) begin
                     ctl.key_we = 1'b1;
                     key_len_in = key_len_inc;
                  end
                  if (req_tlast) begin
                     ctl.sched_go = 1'b1;
                     key_len_in   = '0;
                     st_in        = T_WAIT;
                  end
               end else begin
                  data_in = req_tdata;
                  if (keyed_ff) begin
                     ctl.gen_go = 1'b1;
                     st_in      = T_WAIT;
                  end else begin
                     // no key yet: answer zero and flag it
                     res_in = '0;
                     nk_in  = 1'b1;
                     st_in  = T_RESP;
                  end
               end
            end
         end
         T_WAIT: begin
            if (sts.sched_done) begin
               keyed_in = 1'b1;
               st_in    = T_IDLE;
            end else if (sts.ks_valid) begin
               res_in = ks_only_ff ? sts.ks_byte : (sts.ks_byte ^ data_ff);
               nk_in  = 1'b0;
               st_in  = T_RESP;
            end
         end
         T_RESP: begin
            // hold until the output register frees up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_ff;
               rsp_tuser_in  = nk_ff;
               st_in         = T_IDLE;
            end
         end
         default: begin
            st_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= T_IDLE;
         key_len_ff    <= '0;
         keyed_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         key_len_ff    <= key_len_in;
         keyed_ff      <= keyed_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      res_ff       <= res_in;
      nk_ff        <= nk_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // configuration registers; unknown indexes drop silently
   always_ff @(posedge clock) begin
      if (reset) begin
         discard_ff <= DISCARD_RESET;
         ks_only_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DISCARD_COUNT) begin
            discard_ff <= csr_data[DISCARD_W-1:0];
         end else if (csr_index == CSR_KEYSTREAM_ONLY) begin
            ks_only_ff <= csr_data[0];
         end
      end
   end

   // engine runs only while the front end waits on it
   a_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> (st_ff == T_WAIT))
      else $error("engine busy outside wait state");

   // keystream byte only ever arrives for an accepted data byte
   a_ks_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.ks_valid |-> (st_ff == T_WAIT) && !keyed_in == !keyed_ff)
      else $error("keystream byte outside generation");

   // an error word always carries a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tuser_ff) |-> (rsp_tdata_ff == '0))
      else $error("not_keyed word with nonzero data");

   // key length never passes the store depth
   a_key_len: assert property (@(posedge clock) disable iff (reset)
      key_len_ff <= LEN_W'(KEY_MAX_BYTES))
      else $error("key length overflow");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the RC4 drop-N keystream cipher.
module tb_top
   import rc4ks_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // one word on the request side: key or data byte
   typedef struct packed {
      logic       cmd;
      logic [7:0] value;
      logic       last;
   } cipher_word_type;

   // one word on the response side
   typedef struct packed {
      logic [7:0] result;
      logic       not_keyed;
   } cipher_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   rc4_keystream_cipher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- cipher state mirror
   logic [7:0]           sbox [TABLE_SIZE];
   logic [7:0]           key_mem [TABLE_SIZE];
   logic [7:0]           ptr_i = 8'h00;
   logic [7:0]           ptr_j = 8'h00;
   logic [8:0]           key_len = 9'd0;
   logic                 keyed = 1'b0;
   logic [DISCARD_W-1:0] drop_cfg = DISCARD_RESET;
   logic                 raw_cfg = 1'b0;

   cipher_word_type   send_q [$];
   cipher_result_type cipher_expect_q [$];
   int unsigned       err_count = 0;

   // advance the generator by one byte
   function automatic logic [7:0] keystream_step();
      logic [7:0] si;
      logic [7:0] sj;
      logic [7:0] t;
      ptr_i = ptr_i + 8'd1;
      si = sbox[ptr_i];
      ptr_j = ptr_j + si;
      sj = sbox[ptr_j];
      sbox[ptr_i] = sj;
      sbox[ptr_j] = si;
      t = si + sj;
      return sbox[t];
   endfunction

   // identity, key mix with the key repeated, then drop drop_cfg bytes
   function automatic void run_key_schedule();
      logic [7:0]  j;
      logic [7:0]  t;
      int unsigned kidx;
      for (int n = 0; n < TABLE_SIZE; n++) sbox[n] = 8'(n);
      j = 8'h00;
      kidx = 0;
      for (int n = 0; n < TABLE_SIZE; n++) begin
         t = sbox[n];
         j = j + t + key_mem[kidx];
         sbox[n] = sbox[j];
         sbox[j] = t;
         kidx++;
         if (kidx >= key_len) kidx = 0;
      end
      ptr_i = 8'h00;
      ptr_j = 8'h00;
      for (int n = 0; n < drop_cfg; n++) void'(keystream_step());
      keyed = 1'b1;
      key_len = 9'd0;
   endfunction

   // fold one accepted request word into the mirror and queue its answer
   function automatic void absorb_word(cipher_word_type w);
      logic [7:0] ks;
      if (w.cmd == CMD_KEY) begin
         // drop key bytes past the store size
         if (key_len < 9'(KEY_MAX_DEFAULT)) begin
            key_mem[key_len[7:0]] = w.value;
            key_len = key_len + 9'd1;
         end
         if (w.last) run_key_schedule();
      end else if (!keyed) begin
         cipher_expect_q.push_back('{result: 8'h00, not_keyed: 1'b1});
      end else begin
         ks = keystream_step();
         cipher_expect_q.push_back('{result: raw_cfg ? ks : (ks ^ w.value), not_keyed: 1'b0});
      end
   endfunction

   // idle cycles before the next word; now and then a run of words with no idling
   function automatic int unsigned pick_gap(ref int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(16, 48);
      return $urandom_range(0, 10);
   endfunction

   // ---------------------------------------------------------------- request driver
   cipher_word_type held = '0;
   logic            offer = 1'b0;
   int unsigned     send_wait = 0;
   int unsigned     calm_send = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_word(held);
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (send_q.size() != 0) begin
               held = send_q.pop_front();
               offer = 1'b1;
               send_wait = pick_gap(calm_send);
            end
         end
         req_tvalid <= offer;
         req_tdata  <= held.value;
         req_tuser  <= held.cmd;
         req_tlast  <= held.last;
      end
   end

   // ---------------------------------------------------------------- response monitor
   cipher_result_type want;
   int unsigned       rcv_wait = 0;
   int unsigned       calm_rcv = 0;
   int unsigned       words_seen = 0;
   logic [15:0]       hold_left = 16'd0;
   logic [1:0]        holds_done = 2'd0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen <= words_seen + 1;
            if (cipher_expect_q.size() == 0) begin
               $error("rsp word with nothing pending: result_value %02h not_keyed %0b",
                      rsp_tdata, rsp_tuser);
               err_count++;
            end else begin
               want = cipher_expect_q.pop_front();
               if (rsp_tdata !== want.result) begin
                  $error("result_value: expected %02h, got %02h", want.result, rsp_tdata);
                  err_count++;
               end
               if (rsp_tuser !== want.not_keyed) begin
                  $error("not_keyed: expected %0b, got %0b", want.not_keyed, rsp_tuser);
                  err_count++;
               end
            end
            rcv_wait = pick_gap(calm_rcv);
         end else if (rcv_wait != 0) begin
            rcv_wait--;
         end
         rsp_tready <= (rcv_wait == 0) && (hold_left == 16'd0);
      end
   end

   // hold off the response side for long stretches so the block backs up into req
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 16'd0;
         holds_done <= 2'd0;
      end else if (hold_left != 16'd0) begin
         hold_left <= hold_left - 16'd1;
      end else if ((holds_done == 2'd0 && words_seen == 150) ||
                   (holds_done == 2'd1 && words_seen == 500)) begin
         hold_left  <= 16'd400;
         holds_done <= holds_done + 2'd1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic void queue_word(logic cmd, logic [7:0] value, logic last);
      send_q.push_back('{cmd: cmd, value: value, last: last});
   endfunction

   // load a key of len bytes, last one marked; return the bytes the store keeps
   function automatic int unsigned queue_key(int unsigned len);
      for (int unsigned k = 0; k < len; k++)
         queue_word(CMD_KEY, 8'($urandom), k == len - 1);
      return (len > KEY_MAX_DEFAULT) ? KEY_MAX_DEFAULT : len;
   endfunction

   // n data bytes, with a stray unmarked key byte slipped in now and then
   function automatic int unsigned queue_data(int unsigned n);
      int unsigned cnt;
      cnt = 0;
      for (int unsigned k = 0; k < n; k++) begin
         queue_word(CMD_DATA, 8'($urandom), 1'($urandom));
         cnt++;
         if (k != n - 1 && $urandom_range(0, 15) == 0) begin
            queue_word(CMD_KEY, 8'($urandom), 1'b0);
            cnt++;
         end
      end
      return cnt;
   endfunction

   // drain: everything sent and answered, then a pause for any schedule tail
   task automatic settle(int unsigned tail);
      while (send_q.size() != 0 || offer || cipher_expect_q.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // indexes past the register list fall through untouched
      if (idx == CSR_DISCARD_COUNT) drop_cfg = value;
      else if (idx == CSR_KEYSTREAM_ONLY) raw_cfg = value[0];
   endtask

   initial begin
      int unsigned total;
      int unsigned phase;
      int unsigned segs;
      int unsigned sel;
      int unsigned len;
      logic [DISCARD_W-1:0] drop;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // data ahead of any key: error answer, marker ignored on data
      queue_word(CMD_DATA, 8'h00, 1'b0);
      queue_word(CMD_DATA, 8'hFF, 1'b1);
      // one-byte zero key under the reset drop count
      queue_word(CMD_KEY, 8'h00, 1'b1);
      queue_word(CMD_DATA, 8'h00, 1'b0);
      queue_word(CMD_DATA, 8'hFF, 1'b0);
      queue_word(CMD_DATA, 8'h5A, 1'b1);
      settle(20);

      write_csr(CSR_DISCARD_COUNT, 16'h0000);
      write_csr(CSR_KEYSTREAM_ONLY, 16'hFFFF);
      queue_word(CMD_KEY, 8'hFF, 1'b0);
      queue_word(CMD_KEY, 8'h01, 1'b0);
      queue_word(CMD_KEY, 8'h80, 1'b1);
      queue_word(CMD_DATA, 8'h00, 1'b0);
      queue_word(CMD_DATA, 8'hFF, 1'b0);
      queue_word(CMD_DATA, 8'h33, 1'b0);
      // partial key: old permutation stays live until the marked byte
      queue_word(CMD_KEY, 8'h12, 1'b0);
      queue_word(CMD_DATA, 8'hC3, 1'b0);
      queue_word(CMD_KEY, 8'h34, 1'b1);
      queue_word(CMD_DATA, 8'hAA, 1'b0);
      settle(20);

      write_csr(CSR_KEYSTREAM_ONLY, 16'hFFFE);
      write_csr(8'h02, 16'hFFFF);
      write_csr(8'hFF, 16'h1234);
      queue_word(CMD_DATA, 8'h00, 1'b0);
      queue_word(CMD_DATA, 8'hFF, 1'b1);
      settle(20);

      // random phases: new settings, then keys followed by data bursts
      total = 0;
      phase = 0;
      while (total < 900) begin
         drop = (phase == 2) ? 16'hFFFF : 16'($urandom_range(0, 48));
         write_csr(CSR_DISCARD_COUNT, drop);
         write_csr(CSR_KEYSTREAM_ONLY, 16'($urandom));
         if ($urandom_range(0, 2) == 0)
            write_csr(8'($urandom_range(2, 255)), 16'($urandom));
         // keep the full-drop phase short, since each of its key schedules drops the largest discard count
         segs = (phase == 2) ? 1 : $urandom_range(3, 6);
         repeat (segs) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) len = KEY_MAX_DEFAULT;
            else if (sel == 1) len = $urandom_range(KEY_MAX_DEFAULT + 1, KEY_MAX_DEFAULT + 24);
            else len = $urandom_range(1, 16);
            total += queue_key(len);
            total += queue_data($urandom_range(4, 40));
         end
         settle(20);
         phase++;
      end

      settle(60);
      if (cipher_expect_q.size() != 0) begin
         $error("%0d rsp words never arrived", cipher_expect_q.size());
         err_count++;
      end
      if (err_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #30ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
